[rtl/julian_date_day_number_convert_core_assert.svh]
// ---------------------------------------------------------------------------
// Julian date converter assertion macros
// Shared assertion forms; the user supplies clk and arst_n in scope.
// ---------------------------------------------------------------------------
`ifndef JULIAN_DATE_DAY_NUMBER_CONVERT_CORE_ASSERT_SVH
`define JULIAN_DATE_DAY_NUMBER_CONVERT_CORE_ASSERT_SVH

// same-cycle implication
`define JDC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define JDC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/jdc_pkg.sv]
// ---------------------------------------------------------------------------
// jdc_pkg
// Types, constants and tables of the Julian date converter.
// ---------------------------------------------------------------------------
package jdc_pkg;

	localparam int NUM_STAGES = 7;

	localparam int YEAR_W   = 21;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int DAYNUM_W = 30;

	localparam logic signed [YEAR_W-1:0]   YEAR_MAX = 21'sd1000000;
	localparam logic signed [YEAR_W-1:0]   YEAR_MIN = -21'sd1000000;
	localparam logic signed [DAYNUM_W-1:0] DAY_MAX  = 30'sd400000000;
	localparam logic signed [DAYNUM_W-1:0] DAY_MIN  = -30'sd400000000;

	// year estimate: floor((4*dn + 1468) / 1461), biased positive by DIV_OFS quotients
	localparam longint DIV_OFS = 1100000;
	localparam logic signed [33:0] DIV_BIAS = 34'(1468 + 1461 * DIV_OFS);
	localparam logic signed [22:0] Q_OFS    = 23'(DIV_OFS);
	localparam logic [31:0] YEAR_RECIP = 32'((64'd1 << 42) / 64'd1461);
	localparam logic [13:0] MON_RECIP  = 14'(((1 << 22) + 366) / 367);

	typedef struct packed {
		logic [NUM_STAGES-1:0] en;
	} pipe_ctrl_t;

	typedef struct packed {
		logic                op;
		logic                err;
		logic                leap;
		logic [YEAR_W-1:0]   year;
		logic [MONTH_W-1:0]  month;
		logic [DAY_W-1:0]    day;
		logic [DAYNUM_W-1:0] dn;
	} carry_t;

	// floor((367*m - 362) / 12)
	function automatic logic signed [9:0] month_base(input logic [MONTH_W-1:0] m);
		logic signed [9:0] r;
		unique case (m)
			4'd0:  r = -10'sd31;
			4'd1:  r = 10'sd0;
			4'd2:  r = 10'sd31;
			4'd3:  r = 10'sd61;
			4'd4:  r = 10'sd92;
			4'd5:  r = 10'sd122;
			4'd6:  r = 10'sd153;
			4'd7:  r = 10'sd183;
			4'd8:  r = 10'sd214;
			4'd9:  r = 10'sd245;
			4'd10: r = 10'sd275;
			4'd11: r = 10'sd306;
			4'd12: r = 10'sd336;
			4'd13: r = 10'sd367;
			4'd14: r = 10'sd398;
			4'd15: r = 10'sd428;
		endcase
		return r;
	endfunction

	// month offset after February: -1 in a leap year, else -2
	function automatic logic signed [2:0] month_adj(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic signed [2:0] r;
		if (m > 4'd2) begin
			r = leap ? -3'sd1 : -3'sd2;
		end else begin
			r = 3'sd0;
		end
		return r;
	endfunction

endpackage

[rtl/jdc_ctrl.sv]
// ---------------------------------------------------------------------------
// jdc_ctrl
// Valid bits and per-stage advance enables; bubbles collapse under stall.
// ---------------------------------------------------------------------------
module jdc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output jdc_pkg::pipe_ctrl_t ctrl
);

	logic [jdc_pkg::NUM_STAGES-1:0] valid_q;
	logic [jdc_pkg::NUM_STAGES-1:0] en;

	always_comb begin
		en[jdc_pkg::NUM_STAGES-1] = !valid_q[jdc_pkg::NUM_STAGES-1] || !out_stall;
		for (int k = jdc_pkg::NUM_STAGES - 2; k >= 0; k--) begin
			en[k] = !valid_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[0]) begin
				valid_q[0] <= in_valid;
			end
			for (int k = 1; k < jdc_pkg::NUM_STAGES; k++) begin
				if (en[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	assign ctrl.en   = en;
	assign in_stall  = !en[0];
	assign out_valid = valid_q[jdc_pkg::NUM_STAGES-1];

endmodule

[rtl/jdc_datapath.sv]
// ---------------------------------------------------------------------------
// jdc_datapath
// Seven-stage conversion datapath, date to day number and back.
// ---------------------------------------------------------------------------
module jdc_datapath (
	input  logic                       clk,
	input  jdc_pkg::pipe_ctrl_t        ctrl,
	input  logic                       operation,
	input  logic signed [20:0]         in_year,
	input  logic [3:0]                 in_month,
	input  logic [4:0]                 in_day,
	input  logic signed [29:0]         in_day_number,
	output logic signed [20:0]         out_year,
	output logic [3:0]                 out_month,
	output logic [4:0]                 out_day,
	output logic signed [29:0]         out_day_number,
	output logic                       leap_year,
	output logic                       range_error
);

	jdc_pkg::carry_t c_s1, c_s2, c_s3, c_s4, c_s5, c_s6;
	logic signed [21:0] ym1_s1;
	logic signed [9:0]  tadj_s1;
	logic [31:0]        u_s1, u_s2;
	logic [21:0]        q0_s2, q_s3;
	logic signed [22:0] ym1_s4;
	logic [20:0]        ny_s4, ny_s5, ny_s6;
	logic [9:0]         prior_s5, prior_s6;
	logic [3:0]         nm_s6;

	// stage 1: range checks, year shift, month table, biased numerator
	logic               yr_err, dn_err, leap0;
	logic signed [20:0] y0;
	logic signed [33:0] un;

	always_comb begin
		yr_err = (in_year == '0) || (in_year > jdc_pkg::YEAR_MAX) ||
			(in_year < jdc_pkg::YEAR_MIN);
		dn_err = (in_day_number > jdc_pkg::DAY_MAX) || (in_day_number < jdc_pkg::DAY_MIN);
		y0     = (in_year < 0) ? in_year + 21'sd1 : in_year;
		leap0  = (y0[1:0] == 2'b00);
		un     = (34'(in_day_number) <<< 2) + jdc_pkg::DIV_BIAS;
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[0]) begin
			c_s1.op    <= operation;
			c_s1.err   <= operation ? dn_err : yr_err;
			c_s1.leap  <= !operation && !yr_err && leap0;
			c_s1.year  <= in_year;
			c_s1.month <= in_month;
			c_s1.day   <= in_day;
			c_s1.dn    <= in_day_number;
			ym1_s1     <= 22'(y0) - 22'sd1;
			tadj_s1    <= jdc_pkg::month_base(in_month) +
				10'(jdc_pkg::month_adj(in_month, leap0));
			u_s1       <= un[31:0];
		end
	end

	// stage 2: day number of a date; reciprocal multiply for the year
	logic signed [31:0] ym1_x, fx;
	logic [63:0]        prod_y;

	always_comb begin
		ym1_x  = 32'(ym1_s1);
		fx     = ym1_x * 32'sd365 + (ym1_x >>> 2) + 32'(tadj_s1) +
			$signed(32'(c_s1.day)) - 32'sd2;
		prod_y = 64'(u_s1) * 64'(jdc_pkg::YEAR_RECIP);
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[1]) begin
			c_s2 <= c_s1;
			if (!c_s1.op && !c_s1.err) begin
				c_s2.dn <= fx[29:0];
			end
			q0_s2 <= prod_y[63:42];
			u_s2  <= u_s1;
		end
	end

	// stage 3: quotient correction
	logic [32:0] rem;

	always_comb begin
		rem = {1'b0, u_s2} - 33'(q0_s2) * 33'd1461;
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[2]) begin
			c_s3 <= c_s2;
			q_s3 <= q0_s2 + 22'(rem >= 33'd1461);
		end
	end

	// stage 4: year from the estimate
	logic signed [22:0] approx;
	logic               ny_err;

	always_comb begin
		approx = $signed({1'b0, q_s3}) - jdc_pkg::Q_OFS;
		ny_err = (approx > 23'sd1000000) || (approx < -23'sd999999);
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[3]) begin
			c_s4 <= c_s3;
			if (c_s3.op && !c_s3.err) begin
				c_s4.err  <= ny_err;
				c_s4.leap <= !ny_err && (approx[1:0] == 2'b00);
			end
			ym1_s4 <= approx - 23'sd1;
			ny_s4  <= (approx <= 0) ? 21'(approx - 23'sd1) : 21'(approx);
		end
	end

	// stage 5: days since January 1 of that year
	logic signed [31:0] jx, jan1, prior;

	always_comb begin
		jx    = 32'(ym1_s4);
		jan1  = jx * 32'sd365 + (jx >>> 2) - 32'sd1;
		prior = 32'($signed(c_s4.dn)) - jan1;
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[4]) begin
			c_s5     <= c_s4;
			prior_s5 <= prior[9:0];
			ny_s5    <= ny_s4;
		end
	end

	// stage 6: month by reciprocal multiply
	logic [9:0]  thr, v;
	logic [1:0]  corr;
	logic [13:0] w;
	logic [27:0] prod_m;

	always_comb begin
		thr    = c_s5.leap ? 10'd60 : 10'd59;
		corr   = (prior_s5 < thr) ? 2'd0 : (c_s5.leap ? 2'd1 : 2'd2);
		v      = prior_s5 + 10'(corr);
		w      = 14'(v) * 14'd12 + 14'd373;
		prod_m = 28'(w) * 28'(jdc_pkg::MON_RECIP);
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[5]) begin
			c_s6     <= c_s5;
			prior_s6 <= prior_s5;
			ny_s6    <= ny_s5;
			nm_s6    <= prod_m[25:22];
		end
	end

	// stage 7: day of month, result select
	logic signed [10:0] nd;

	always_comb begin
		nd = $signed({1'b0, prior_s6}) + 11'sd1 - 11'(jdc_pkg::month_base(nm_s6)) -
			11'(jdc_pkg::month_adj(nm_s6, c_s6.leap));
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[6]) begin
			if (c_s6.op && !c_s6.err) begin
				out_year  <= ny_s6;
				out_month <= nm_s6;
				out_day   <= nd[4:0];
			end else begin
				out_year  <= c_s6.year;
				out_month <= c_s6.month;
				out_day   <= c_s6.day;
			end
			out_day_number <= c_s6.dn;
			leap_year      <= c_s6.leap;
			range_error    <= c_s6.err;
		end
	end

endmodule

[rtl/julian_date_day_number_convert_core.sv]
// ---------------------------------------------------------------------------
// julian_date_day_number_convert_core
// Proleptic Julian date <-> fixed day number converter.
// ---------------------------------------------------------------------------
// Operation 0 turns year/month/day into a fixed day number, operation 1 turns
// a day number into year/month/day; both report the leap-year flag, and
// range_error marks year zero or a value out of range, with the value fields
// echoing the inputs. One beat is accepted every cycle while in_stall is low;
// out_valid rises when the beat reaches the last stage register, and the
// output handshake takes place while out_stall is low. The depth
// is set by the year estimate, a reciprocal multiply by 1461 with one
// correction step, followed by the month multiply by a reciprocal of 367.
// Empty stages fill in under an output stall, so input stall only rises once
// all seven stages hold beats.
// ---------------------------------------------------------------------------
module julian_date_day_number_convert_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                operation,
	input  logic signed [20:0]  in_year,
	input  logic [3:0]          in_month,
	input  logic [4:0]          in_day,
	input  logic signed [29:0]  in_day_number,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [20:0]  out_year,
	output logic [3:0]          out_month,
	output logic [4:0]          out_day,
	output logic signed [29:0]  out_day_number,
	output logic                leap_year,
	output logic                range_error
);

	jdc_pkg::pipe_ctrl_t ctrl;

	jdc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctrl      (ctrl)
	);

	jdc_datapath u_dp (
		.clk            (clk),
		.ctrl           (ctrl),
		.operation      (operation),
		.in_year        (in_year),
		.in_month       (in_month),
		.in_day         (in_day),
		.in_day_number  (in_day_number),
		.out_year       (out_year),
		.out_month      (out_month),
		.out_day        (out_day),
		.out_day_number (out_day_number),
		.leap_year      (leap_year),
		.range_error    (range_error)
	);

endmodule

[rtl/jdc_checker.sv]
// ---------------------------------------------------------------------------
// jdc_port_checker
// Port-level checks of the Julian date converter, bound to the top level.
// ---------------------------------------------------------------------------
`include "julian_date_day_number_convert_core_assert.svh"

module jdc_port_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [20:0] out_year,
	input logic [3:0]         out_month,
	input logic [4:0]         out_day,
	input logic signed [29:0] out_day_number,
	input logic               leap_year,
	input logic               range_error
);

	logic [60:0] out_bus;

	assign out_bus = {out_year, out_month, out_day, out_day_number, range_error};

	`JDC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_bus), "stalled output beat changed")
	`JDC_ASSERT_NOW(a_err_no_leap, out_valid && range_error, !leap_year, "leap flag on a failed beat")
	`JDC_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without output back-pressure")
	`JDC_ASSERT_NOW(a_fill, in_valid && !out_stall, !in_stall, "beat refused while output drains")

endmodule

bind julian_date_day_number_convert_core jdc_port_checker u_jdc_checker (.*);

[sim/jdc_checker.sv]
// ---------------------------------------------------------------------------
// jdc_checker
// Watches both channels of the Julian date converter, predicts every result
// from the accepted input beat and compares it field by field, in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module jdc_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic                operation,
	input  logic signed [20:0]  in_year,
	input  logic [3:0]          in_month,
	input  logic [4:0]          in_day,
	input  logic signed [29:0]  in_day_number,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic signed [20:0]  out_year,
	input  logic [3:0]          out_month,
	input  logic [4:0]          out_day,
	input  logic signed [29:0]  out_day_number,
	input  logic                leap_year,
	input  logic                range_error,
	output int                  fail_count,
	output int                  pending
);

	localparam longint EPOCH = -1;

	typedef struct packed {
		logic [jdc_pkg::YEAR_W-1:0]   year;
		logic [jdc_pkg::MONTH_W-1:0]  month;
		logic [jdc_pkg::DAY_W-1:0]    day;
		logic [jdc_pkg::DAYNUM_W-1:0] dn;
		logic                         leap;
		logic                         err;
	} conv_t;

	conv_t expected_q[$];

	function automatic longint floor_div(input longint a, input longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0) begin
			q = q - 1;
		end
		return q;
	endfunction

	function automatic bit julian_leap(input longint yr);
		longint m;
		m = yr - 4 * floor_div(yr, 4);
		return m == ((yr > 0) ? 0 : 3);
	endfunction

	function automatic longint day_of(input longint yr, input longint mo, input longint dy);
		longint y;
		longint adj;
		y = (yr < 0) ? yr + 1 : yr;
		adj = (mo <= 2) ? 0 : (julian_leap(yr) ? -1 : -2);
		return EPOCH - 1 + 365 * (y - 1) + floor_div(y - 1, 4)
			+ floor_div(367 * mo - 362, 12) + adj + dy;
	endfunction

	function automatic conv_t convert_date(input logic op, input logic signed [20:0] yr_i,
		input logic [3:0] mo_i, input logic [4:0] dy_i, input logic signed [29:0] dn_i);
		conv_t r;
		longint yr, mo, dy, dn, approx, ny, prior, corr, nm, nd;
		yr = longint'(yr_i);
		mo = longint'(mo_i);
		dy = longint'(dy_i);
		dn = longint'(dn_i);
		r.year = yr_i;
		r.month = mo_i;
		r.day = dy_i;
		r.dn = dn_i;
		r.leap = 1'b0;
		r.err = 1'b0;
		if (op == 1'b0) begin
			if (yr == 0 || yr > 1000000 || yr < -1000000) begin
				r.err = 1'b1;
			end else begin
				r.dn = 30'(day_of(yr, mo, dy));
				r.leap = julian_leap(yr);
			end
		end else if (dn > 400000000 || dn < -400000000) begin
			r.err = 1'b1;
		end else begin
			approx = floor_div(4 * (dn - EPOCH) + 1464, 1461);
			ny = (approx <= 0) ? approx - 1 : approx;
			if (ny > 1000000 || ny < -1000000) begin
				r.err = 1'b1;
			end else begin
				prior = dn - day_of(ny, 1, 1);
				corr = (dn < day_of(ny, 3, 1)) ? 0 : (julian_leap(ny) ? 1 : 2);
				nm = floor_div(12 * (prior + corr) + 373, 367);
				nd = dn - day_of(ny, nm, 1) + 1;
				r.year = 21'(ny);
				r.month = 4'(nm);
				r.day = 5'(nd);
				r.leap = julian_leap(ny);
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		conv_t exp_r, got;
		if (!arst_n) begin
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_q.push_back(convert_date(operation, in_year, in_month, in_day,
					in_day_number));
			end
			if (out_valid && !out_stall) begin
				got = {out_year, out_month, out_day, out_day_number, leap_year, range_error};
				if (expected_q.size() == 0) begin
					if (fail_count < 10) begin
						$display("unexpected result beat at %0t", $time);
					end
					fail_count <= fail_count + 1;
				end else begin
					exp_r = expected_q.pop_front();
					if (got !== exp_r) begin
						if (fail_count < 10) begin
							$display("mismatch at %0t: exp y=%0d m=%0d d=%0d dn=%0d lp=%0b er=%0b",
								$time, $signed(exp_r.year), exp_r.month, exp_r.day,
								$signed(exp_r.dn), exp_r.leap, exp_r.err);
							$display("                 got y=%0d m=%0d d=%0d dn=%0d lp=%0b er=%0b",
								out_year, out_month, out_day, out_day_number, leap_year,
								range_error);
						end
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= expected_q.size();
		end
	end

endmodule

[sim/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top
// Drives the Julian date converter with directed corner beats and random
// conversions in both directions, under random idle and stall bursts until a final quiet run.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               operation;
	logic signed [20:0] in_year;
	logic [3:0]         in_month;
	logic [4:0]         in_day;
	logic signed [29:0] in_day_number;
	logic               out_valid;
	logic               out_stall;
	logic signed [20:0] out_year;
	logic [3:0]         out_month;
	logic [4:0]         out_day;
	logic signed [29:0] out_day_number;
	logic               leap_year;
	logic               range_error;
	int                 fail_count;
	int                 pending;
	bit                 quiet;
	bit                 bursts_on;

	julian_date_day_number_convert_core i_dut (.*);

	jdc_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("Verification failed");
		$finish;
	end

	// output stall bursts
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_beat(input logic op, input logic signed [20:0] yr,
		input logic [3:0] mo, input logic [4:0] dy, input logic signed [29:0] dn);
		if (bursts_on && !quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		in_year <= yr;
		in_month <= mo;
		in_day <= dy;
		in_day_number <= dn;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_random;
		logic op;
		logic signed [20:0] yr;
		logic [3:0] mo;
		logic [4:0] dy;
		logic signed [29:0] dn;
		op = 1'($urandom_range(0, 1));
		yr = 21'($urandom);
		mo = 4'($urandom);
		dy = 5'($urandom);
		dn = 30'($urandom);
		if ($urandom_range(0, 9) != 0) begin
			yr = $urandom_range(0, 1) ? 21'($urandom_range(1, 1000000))
				: -21'($urandom_range(1, 1000000));
			if ($urandom_range(0, 3) != 0) begin
				yr = 21'($signed(32'($urandom_range(0, 6000)) - 3000));
				if (yr == 0) yr = 21'sd1;
			end
			mo = 4'($urandom_range(1, 12));
			dy = 5'($urandom_range(1, 31));
			dn = $urandom_range(0, 1) ? 30'($urandom_range(0, 400000000))
				: -30'($urandom_range(0, 400000000));
			if ($urandom_range(0, 2) != 0) begin
				dn = 30'($signed(32'($urandom_range(0, 2000000)) - 1000000));
			end
		end
		send_beat(op, yr, mo, dy, dn);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = 1'b0;
		in_year = '0;
		in_month = '0;
		in_day = '0;
		in_day_number = '0;
		quiet = 1'b0;
		bursts_on = 1'b1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_beat(1'b0, 21'sd1, 4'd1, 5'd1, 30'sd0);
		send_beat(1'b0, -21'sd1, 4'd12, 5'd31, 30'sd0);
		send_beat(1'b0, 21'sd1000000, 4'd12, 5'd31, -30'sd1);
		send_beat(1'b0, -21'sd1000000, 4'd1, 5'd1, 30'sd1);
		send_beat(1'b0, 21'sd0, 4'd3, 5'd1, 30'sd7);
		send_beat(1'b0, 21'sd1000001, 4'd2, 5'd28, 30'sd9);
		send_beat(1'b0, -21'sd1000001, 4'd2, 5'd29, 30'sd9);
		send_beat(1'b0, -21'sd1048576, 4'd0, 5'd0, 30'sd0);
		send_beat(1'b0, 21'sd1048575, 4'd15, 5'd31, 30'sd0);
		send_beat(1'b0, 21'sd2024, 4'd0, 5'd0, 30'sd0);
		send_beat(1'b0, 21'sd2023, 4'd15, 5'd31, 30'sd0);
		send_beat(1'b0, -21'sd5, 4'd3, 5'd1, 30'sd0);
		send_beat(1'b1, 21'sd0, 4'd0, 5'd0, 30'sd0);
		send_beat(1'b1, 21'sd0, 4'd0, 5'd0, -30'sd1);
		send_beat(1'b1, 21'sd0, 4'd0, 5'd0, -30'sd2);
		send_beat(1'b1, 21'sd5, 4'd5, 5'd5, 30'sd400000000);
		send_beat(1'b1, 21'sd5, 4'd5, 5'd5, -30'sd400000000);
		send_beat(1'b1, 21'sd5, 4'd5, 5'd5, 30'sd400000001);
		send_beat(1'b1, 21'sd5, 4'd5, 5'd5, -30'sd400000001);
		send_beat(1'b1, 21'sd0, 4'd0, 5'd0, -30'sd536870912);
		send_beat(1'b1, 21'sd0, 4'd0, 5'd0, 30'sd536870911);
		send_beat(1'b1, 21'sd0, 4'd0, 5'd0, 30'sd365242000);
		send_beat(1'b1, 21'sd0, 4'd0, 5'd0, -30'sd365243000);
		send_beat(1'b1, 21'sd0, 4'd0, 5'd0, 30'sd59);

		repeat (1000) send_random();
		quiet = 1'b1;
		repeat (150) send_random();
		in_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
